[rtl/core/suts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suts_pkg
// shared types and codes for the sorted unique insert table
// ----------------------------------------------------------------------------
package suts_pkg;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned POS_W   = 4;
	localparam int unsigned OUT_W   = 5;

	// command codes
	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_READ   = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_DUP   = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	// what one cell hands to its right neighbor
	typedef struct packed {
		logic                     lt;     // cell holds a valid entry below the value
		logic                     valid;  // cell holds an entry
		logic signed [DATA_W-1:0] entry;
	} suts_link_t;

	// per-cycle control broadcast to every cell
	typedef struct packed {
		logic shift;  // commit an insert
		logic clear;  // drop all entries
	} suts_ctrl_t;

endpackage

[rtl/core/suts_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suts_cell
// one compare-and-shift slot of the sorted table
// ----------------------------------------------------------------------------
module suts_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  suts_pkg::suts_ctrl_t              ctrl,
	input  logic signed [suts_pkg::DATA_W-1:0] value,
	input  suts_pkg::suts_link_t              left,
	output suts_pkg::suts_link_t              right,
	output logic                              eq,
	output logic                              boundary
);
	import suts_pkg::*;

	logic                     valid_q;
	logic signed [DATA_W-1:0] entry_q;
	logic                     lt;

	assign lt       = valid_q && (entry_q < value);
	assign eq       = valid_q && (entry_q == value);
	// first slot whose entry is not below the value
	assign boundary = left.lt && !lt;

	assign right.lt    = lt;
	assign right.valid = valid_q;
	assign right.entry = entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= valid_q | left.valid;
		end
	end

	// smaller entries stay, the boundary slot takes the value, the rest shift right
	always_ff @(posedge clk) begin
		if (ctrl.shift && !lt) begin
			entry_q <= left.lt ? value : left.entry;
		end
	end

endmodule

[rtl/core/sorted_unique_insert_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_unique_insert_table
// ascending table of distinct signed values held in a chain of cells
// ----------------------------------------------------------------------------
// usage
//   command channel: drive mode, value and position with start high; a beat
//   is taken at any rising edge where start is high and busy is low. busy
//   stays low, so a command may be given in every cycle.
//   result channel: done is high for exactly one cycle with status, where,
//   entry_value and entry_count; the receiver must take it in that cycle,
//   there is no way to stall it.
// pipeline and throughput
//   the command is registered at the edge it is taken, the cell row compares
//   during the next cycle, and the cells shift and the result register loads
//   at the following edge, where done rises. one command per cycle is
//   sustained; every cell compares against the value in parallel, so the
//   time an insert takes does not grow with capacity.
// reset
//   arst_n clears all valid bits and the count, so the table starts empty.
//   entry storage has no reset and is only read behind a valid bit.
// ----------------------------------------------------------------------------
module sorted_unique_insert_table #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// command channel
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          mode,
	input  logic signed [suts_pkg::DATA_W-1:0]  value,
	input  logic [suts_pkg::POS_W-1:0]          position,
	// result channel
	output logic                                done,
	output logic [1:0]                          status,
	output logic [suts_pkg::OUT_W-1:0]          where,
	output logic signed [suts_pkg::DATA_W-1:0]  entry_value,
	output logic [suts_pkg::OUT_W-1:0]          entry_count
);
	import suts_pkg::*;

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	// command stage
	logic                     cmd_valid_s1;
	logic [1:0]               mode_s1;
	logic signed [DATA_W-1:0] value_s1;
	logic [POS_W-1:0]         position_s1;

	// occupancy
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;

	// cell row
	suts_link_t           link [0:CAPACITY];
	logic [CAPACITY-1:0]  eq_vec;
	logic [CAPACITY-1:0]  boundary_vec;
	logic [CAPACITY-1:0]  sel_vec;
	suts_ctrl_t           ctrl;

	// decoded per-command results
	logic                     is_insert;
	logic                     is_read;
	logic                     is_clear;
	logic                     dup;
	logic                     full;
	logic [CNT_W-1:0]         smaller;
	logic                     rd_hit;
	logic signed [DATA_W-1:0] rd_entry;
	logic [1:0]               status_next;
	logic [OUT_W-1:0]         where_next;
	logic signed [DATA_W-1:0] entry_next;

	// the row never blocks, a command can enter every cycle
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else begin
			cmd_valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			mode_s1     <= mode;
			value_s1    <= value;
			position_s1 <= position;
		end
	end

	assign is_insert = cmd_valid_s1 && (mode_s1 == MODE_INSERT);
	assign is_read   = cmd_valid_s1 && (mode_s1 == MODE_READ);
	assign is_clear  = cmd_valid_s1 && (mode_s1 == MODE_CLEAR);

	// left end of the row: acts as a smaller, valid neighbor
	assign link[0].lt    = 1'b1;
	assign link[0].valid = 1'b1;
	assign link[0].entry = '0;

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			assign sel_vec[gi] = (32'(position_s1) == gi);
			suts_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.value    (value_s1),
				.left     (link[gi]),
				.right    (link[gi+1]),
				.eq       (eq_vec[gi]),
				.boundary (boundary_vec[gi])
			);
		end
	endgenerate

	assign dup  = |eq_vec;
	// last cell occupied means count has reached capacity
	assign full = link[CAPACITY].valid;

	assign ctrl.shift = is_insert && !dup && !full;
	assign ctrl.clear = is_clear;

	// insert position: index of the one boundary cell, or capacity when every
	// stored entry is smaller; read data: or of the selected cell
	always_comb begin
		smaller  = link[CAPACITY].lt ? CNT_W'(CAPACITY) : '0;
		rd_hit   = 1'b0;
		rd_entry = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (boundary_vec[i]) begin
				smaller = smaller | CNT_W'(i);
			end
			if (sel_vec[i]) begin
				rd_hit   = rd_hit | link[i+1].valid;
				rd_entry = rd_entry | link[i+1].entry;
			end
		end
	end

	always_comb begin
		count_next = count_q;
		if (ctrl.clear) begin
			count_next = '0;
		end else if (ctrl.shift) begin
			count_next = count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	// result fields; where and count wrap to the port width
	always_comb begin
		status_next = ST_OK;
		where_next  = '0;
		entry_next  = '0;
		if (is_insert) begin
			where_next = OUT_W'({{OUT_W{1'b0}}, smaller});
			if (dup) begin
				status_next = ST_DUP;
			end else if (full) begin
				status_next = ST_FULL;
			end
		end else if (is_read) begin
			where_next = OUT_W'(position_s1);
			if (rd_hit) begin
				entry_next = rd_entry;
			end else begin
				status_next = ST_RANGE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid_s1) begin
			status      <= status_next;
			where       <= where_next;
			entry_value <= entry_next;
			entry_count <= OUT_W'({{OUT_W{1'b0}}, count_next});
		end
	end

endmodule
